/* rtl/shsh_pkg.sv */
// ----------------------------------------------------------------------------
// shsh_pkg
// Types, constants and round functions shared by the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shsh_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } shsh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shsh_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_EMIT
  } shsh_state_t;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;
  localparam logic [3:0] LEN_BYTES  = 4'd8;

  localparam logic [0:7][31:0] INIT_WORDS = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       byte_we;
    logic [7:0] wr_byte;
    logic       word_shift;
  } shsh_msg_ctl_t;

  typedef struct packed {
    logic       load;
    logic       round_en;
    logic       fold;
    logic       init;
    logic [5:0] round_idx;
    logic [2:0] word_sel;
  } shsh_comp_ctl_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    ror32 = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

endpackage

/* rtl/shsh_msg.sv */
// ----------------------------------------------------------------------------
// shsh_msg
// Message window: collects block bytes, then expands the schedule one word
// per round while feeding the current word to the compression unit.
// ----------------------------------------------------------------------------
module shsh_msg (
  input  logic                   clk,
  input  shsh_pkg::shsh_msg_ctl_t ctl,
  output logic [31:0]            sched_word
);

  logic [511:0] win_r;
  logic [511:0] win_nxt;
  logic [31:0]  w0;
  logic [31:0]  w1;
  logic [31:0]  w9;
  logic [31:0]  w14;
  logic [31:0]  w_new;

  assign w0  = win_r[511:480];
  assign w1  = win_r[479:448];
  assign w9  = win_r[223:192];
  assign w14 = win_r[63:32];

  assign w_new      = w0 + shsh_pkg::sig0(w1) + w9 + shsh_pkg::sig1(w14);
  assign sched_word = w0;

  always_comb begin
    win_nxt = win_r;
    if (ctl.byte_we) begin
      win_nxt = {win_r[503:0], ctl.wr_byte};
    end else if (ctl.word_shift) begin
      win_nxt = {win_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

/* rtl/shsh_comp.sv */
// ----------------------------------------------------------------------------
// shsh_comp
// Compression datapath: chaining words, working variables and one shared
// round unit applied once per cycle while round_en is set.
// ----------------------------------------------------------------------------
module shsh_comp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  shsh_pkg::shsh_comp_ctl_t ctl,
  input  logic [31:0]             sched_word,
  output logic [31:0]             digest_word
);

  logic [0:7][31:0] chain_r;
  logic [0:7][31:0] chain_nxt;
  logic [0:7][31:0] work_r;
  logic [0:7][31:0] work_nxt;
  logic [31:0]      t1;
  logic [31:0]      t2;
  logic [31:0]      ch;
  logic [31:0]      maj;

  assign ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t1  = work_r[7] + shsh_pkg::bsig1(work_r[4]) + ch
             + shsh_pkg::ROUND_K[ctl.round_idx] + sched_word;
  assign t2  = shsh_pkg::bsig0(work_r[0]) + maj;

  assign digest_word = chain_r[ctl.word_sel];

  always_comb begin
    work_nxt = work_r;
    if (ctl.load) begin
      work_nxt = chain_r;
    end else if (ctl.round_en) begin
      work_nxt[7] = work_r[6];
      work_nxt[6] = work_r[5];
      work_nxt[5] = work_r[4];
      work_nxt[4] = work_r[3] + t1;
      work_nxt[3] = work_r[2];
      work_nxt[2] = work_r[1];
      work_nxt[1] = work_r[0];
      work_nxt[0] = t1 + t2;
    end
  end

  always_comb begin
    chain_nxt = chain_r;
    if (ctl.init) begin
      chain_nxt = shsh_pkg::INIT_WORDS;
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain_nxt[i] = chain_r[i] + work_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= shsh_pkg::INIT_WORDS;
    end else begin
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

endmodule

/* rtl/sha256_stream_hasher_core.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a byte stream: absorb bytes, finish to pad and emit digest.
// ----------------------------------------------------------------------------
// The byte that completes a 64-byte block starts a compression that runs
// one round per cycle in a single shared round unit, then a fold into the
// chaining words, during which in_ready is low. A finish transaction
// inserts padding and length bytes one per cycle (9 to 72 bytes), runs one
// or two compressions, then offers the eight digest words, word 0 first,
// as eight output transactions; the chaining state then returns to the
// initial vector and in_ready rises again.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  shsh_pkg::shsh_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output shsh_pkg::shsh_out_t out_data
);

  shsh_pkg::shsh_state_t    state_r;
  shsh_pkg::shsh_state_t    state_nxt;
  logic [5:0]               fill_r;
  logic [5:0]               fill_nxt;
  logic [63:0]              total_r;
  logic [63:0]              total_nxt;
  logic [5:0]               rnd_r;
  logic [5:0]               rnd_nxt;
  logic                     mark_r;
  logic                     mark_nxt;
  logic [3:0]               len_cnt_r;
  logic [3:0]               len_cnt_nxt;
  logic [2:0]               idx_r;
  logic [2:0]               idx_nxt;

  shsh_pkg::shsh_msg_ctl_t  msg_ctl;
  shsh_pkg::shsh_comp_ctl_t comp_ctl;
  logic [31:0]              sched_word;
  logic [31:0]              digest_word;
  logic [63:0]              len_bits;
  logic [7:0]               len_byte;
  logic [7:0]               pad_byte;
  logic                     pad_is_len;
  logic                     in_fire;
  logic                     out_fire;
  logic                     block_full;
  logic                     emit_done;

  assign len_bits   = {total_r[60:0], 3'b000};
  assign len_byte   = len_bits[{3'(3'd7 - len_cnt_r[2:0]), 3'b000} +: 8];
  assign pad_is_len = mark_r && ((len_cnt_r != 4'd0) || (fill_r == shsh_pkg::LEN_OFFSET));

  always_comb begin
    if (!mark_r) begin
      pad_byte = shsh_pkg::PAD_MARK;
    end else if (pad_is_len) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;
  assign block_full = msg_ctl.byte_we && (fill_r == shsh_pkg::FILL_LAST);
  assign emit_done  = out_fire && (idx_r == shsh_pkg::WORD_LAST);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shsh_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data.op == shsh_pkg::OP_FINISH) begin
            state_nxt = shsh_pkg::ST_PAD;
          end else if (fill_r == shsh_pkg::FILL_LAST) begin
            state_nxt = shsh_pkg::ST_COMP;
          end
        end
      end
      shsh_pkg::ST_PAD: begin
        if (fill_r == shsh_pkg::FILL_LAST) begin
          state_nxt = shsh_pkg::ST_COMP;
        end
      end
      shsh_pkg::ST_COMP: begin
        if (rnd_r == shsh_pkg::ROUND_LAST) begin
          state_nxt = shsh_pkg::ST_FOLD;
        end
      end
      shsh_pkg::ST_FOLD: begin
        if (len_cnt_r == shsh_pkg::LEN_BYTES) begin
          state_nxt = shsh_pkg::ST_EMIT;
        end else if (mark_r) begin
          state_nxt = shsh_pkg::ST_PAD;
        end else begin
          state_nxt = shsh_pkg::ST_IDLE;
        end
      end
      shsh_pkg::ST_EMIT: begin
        if (emit_done) begin
          state_nxt = shsh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = shsh_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready           = 1'b0;
    out_valid          = 1'b0;
    msg_ctl.byte_we    = 1'b0;
    msg_ctl.wr_byte    = pad_byte;
    msg_ctl.word_shift = 1'b0;
    comp_ctl.round_en  = 1'b0;
    comp_ctl.fold      = 1'b0;
    comp_ctl.init      = 1'b0;
    comp_ctl.round_idx = rnd_r;
    comp_ctl.word_sel  = idx_r;
    unique case (state_r)
      shsh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && (in_data.op == shsh_pkg::OP_ABSORB)) begin
          msg_ctl.byte_we = 1'b1;
          msg_ctl.wr_byte = in_data.data_byte;
        end
      end
      shsh_pkg::ST_PAD: begin
        msg_ctl.byte_we = 1'b1;
      end
      shsh_pkg::ST_COMP: begin
        msg_ctl.word_shift = 1'b1;
        comp_ctl.round_en  = 1'b1;
      end
      shsh_pkg::ST_FOLD: begin
        comp_ctl.fold = 1'b1;
      end
      shsh_pkg::ST_EMIT: begin
        out_valid     = 1'b1;
        comp_ctl.init = emit_done;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    comp_ctl.load = block_full;
  end

  assign out_data.digest_word = digest_word;
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == shsh_pkg::WORD_LAST);

  // counters and flags
  always_comb begin
    fill_nxt    = fill_r;
    total_nxt   = total_r;
    rnd_nxt     = rnd_r;
    mark_nxt    = mark_r;
    len_cnt_nxt = len_cnt_r;
    idx_nxt     = idx_r;
    if (msg_ctl.byte_we) begin
      fill_nxt = fill_r + 6'd1;
    end
    if (in_fire && (in_data.op == shsh_pkg::OP_ABSORB)) begin
      total_nxt = total_r + 64'd1;
    end
    if (state_r == shsh_pkg::ST_PAD) begin
      mark_nxt = 1'b1;
      if (pad_is_len) begin
        len_cnt_nxt = len_cnt_r + 4'd1;
      end
    end
    if (comp_ctl.round_en) begin
      rnd_nxt = rnd_r + 6'd1;
    end
    if (out_fire) begin
      idx_nxt = idx_r + 3'd1;
    end
    if (emit_done) begin
      fill_nxt    = '0;
      total_nxt   = '0;
      mark_nxt    = 1'b0;
      len_cnt_nxt = '0;
      idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= shsh_pkg::ST_IDLE;
      fill_r    <= '0;
      total_r   <= '0;
      rnd_r     <= '0;
      mark_r    <= 1'b0;
      len_cnt_r <= '0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      total_r   <= total_nxt;
      rnd_r     <= rnd_nxt;
      mark_r    <= mark_nxt;
      len_cnt_r <= len_cnt_nxt;
      idx_r     <= idx_nxt;
    end
  end

  shsh_msg u_msg (
    .clk        (clk),
    .ctl        (msg_ctl),
    .sched_word (sched_word)
  );

  shsh_comp u_comp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (comp_ctl),
    .sched_word  (sched_word),
    .digest_word (digest_word)
  );

endmodule
